// ===== rtl/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned DEPTH_OUT_W   = 7;
    localparam int unsigned STACK_DEPTH_D = 64;

    localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] EMPTY_TOP = '0;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } mts_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic single;
    } mts_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mts_datapath.sv =====
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_D
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  mts_ctrl_t                    ctrl,
    output mts_stat_t                    stat,
    input  wire                          cmd,
    input  wire logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0]     top_value,
    output logic signed [DATA_W-1:0]     min_value,
    output logic [DEPTH_OUT_W-1:0]       depth,
    output logic                         empty_res,
    output logic [1:0]                   status
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);
    localparam logic [CW-1:0] TWO        = CW'(2);

    logic [2*DATA_W-1:0]       mem [STACK_DEPTH];
    logic [2*DATA_W-1:0]       rdata_reg;
    logic                      cmd_reg;
    logic signed [DATA_W-1:0]  value_reg;
    logic [CW-1:0]             depth_reg;
    logic signed [DATA_W-1:0]  top_reg;
    logic signed [DATA_W-1:0]  min_reg;
    status_t                   status_reg;

    logic                      full;
    logic                      empty;
    logic signed [DATA_W-1:0]  new_min;
    logic [CW-1:0]             rd_level;
    logic                      do_push;

    assign full     = (depth_reg == FULL_COUNT);
    assign empty    = (depth_reg == '0);
    assign new_min  = (value_reg < min_reg) ? value_reg : min_reg;
    assign rd_level = depth_reg - TWO;
    assign do_push  = ctrl.execute && (cmd_reg == OP_PUSH) && !full;

    assign stat.is_pop = (cmd_reg == OP_POP);
    assign stat.empty  = empty;
    assign stat.single = (depth_reg == ONE);

    // Capture the transaction; the memory holds every level, top/min mirror the top level
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (do_push)
        begin
            mem[depth_reg[AW-1:0]] <= {value_reg, new_min};
        end
        rdata_reg <= mem[rd_level[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            top_reg    <= EMPTY_TOP;
            min_reg    <= EMPTY_MIN;
            status_reg <= ST_OK;
        end
        else if (ctrl.execute)
        begin
            status_reg <= ST_OK;
            if (cmd_reg == OP_PUSH)
            begin
                if (full)
                begin
                    status_reg <= ST_PUSH_FULL;
                end
                else
                begin
                    depth_reg <= depth_reg + ONE;
                    top_reg   <= value_reg;
                    min_reg   <= new_min;
                end
            end
            else if (empty)
            begin
                status_reg <= ST_POP_EMPTY;
            end
            else
            begin
                depth_reg <= depth_reg - ONE;
                // last element gone: fall back to the empty readings
                if (depth_reg == ONE)
                begin
                    top_reg <= EMPTY_TOP;
                    min_reg <= EMPTY_MIN;
                end
            end
        end
        else if (ctrl.load)
        begin
            top_reg <= rdata_reg[2*DATA_W-1:DATA_W];
            min_reg <= rdata_reg[DATA_W-1:0];
        end
    end

    assign top_value = top_reg;
    assign min_value = min_reg;
    assign depth     = DEPTH_OUT_W'(depth_reg);
    assign empty_res = empty;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/mts_controller.sv =====
`default_nettype none

module mts_controller
    import mts_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    output logic       done,
    output mts_ctrl_t  ctrl,
    input  mts_stat_t  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    state_t state_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // a pop that leaves entries behind must fetch the new top
                    if (stat.is_pop && !stat.empty && !stat.single)
                    begin
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign ctrl.capture = (state_reg == S_IDLE) && start;
    assign ctrl.execute = (state_reg == S_EXEC);
    assign ctrl.load    = (state_reg == S_LOAD);

endmodule

`default_nettype wire

// ===== rtl/min_tracking_stack_core.sv =====
`default_nettype none

// Stack of signed 32-bit values that tracks its running minimum. Issue a push
// (cmd 0) or pop (cmd 1) by raising start while busy is low. A push, a pop
// that empties the stack, or any ignored transaction ends after the execute
// state; a pop leaving elements behind adds the load state, as the new top
// must be read back from the entry memory, whose read data is registered. The
// result appears on the output ports for exactly one cycle with done high;
// the receiver cannot stall it, so capture it in that cycle. busy falls in
// the same cycle as done, so a new transaction can be issued while the result
// is shown. Push on full and pop on empty are ignored and flagged in status.

module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_D
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           cmd,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          done,
    output logic signed [DATA_W-1:0]      top_value,
    output logic signed [DATA_W-1:0]      min_value,
    output logic [DEPTH_OUT_W-1:0]        depth,
    output logic                          empty_res,
    output logic [1:0]                    status
);

    mts_ctrl_t ctrl;
    mts_stat_t stat;

    mts_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd       (cmd),
        .value     (value),
        .top_value (top_value),
        .min_value (min_value),
        .depth     (depth),
        .empty_res (empty_res),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/sv/min_tracking_stack_checker.sv =====
`default_nettype none

module min_tracking_stack_checker
    import mts_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire                      busy,
    input  wire                      cmd,
    input  wire [DATA_W-1:0]         value,
    input  wire                      done,
    input  wire [DATA_W-1:0]         top_value,
    input  wire [DATA_W-1:0]         min_value,
    input  wire [DEPTH_OUT_W-1:0]    depth,
    input  wire                      empty_res,
    input  wire [1:0]                status,
    output int                       fail_count,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0]  top;
        logic signed [DATA_W-1:0]  minv;
        logic [DEPTH_OUT_W-1:0]    depth;
        logic                      empty;
        status_t                   st;
    } stack_report_t;

    stack_report_t               report_q[$];
    logic signed [DATA_W-1:0]    value_mem [STACK_DEPTH_D];
    logic signed [DATA_W-1:0]    min_mem   [STACK_DEPTH_D];
    int unsigned                 level = 0;

    // Apply one push or pop to the shadow stack and return what the block should show.
    function automatic stack_report_t apply_op(input logic op,
                                               input logic signed [DATA_W-1:0] v);
        stack_report_t            r;
        logic signed [DATA_W-1:0] below;
        r.st = ST_OK;
        if (op == OP_PUSH)
        begin
            if (level >= STACK_DEPTH_D)
                r.st = ST_PUSH_FULL;
            else
            begin
                below = (level > 0) ? min_mem[level-1] : EMPTY_MIN;
                value_mem[level] = v;
                min_mem[level]   = (v < below) ? v : below;
                level++;
            end
        end
        else if (level == 0)
            r.st = ST_POP_EMPTY;
        else
            level--;
        r.top   = (level > 0) ? value_mem[level-1] : EMPTY_TOP;
        r.minv  = (level > 0) ? min_mem[level-1]   : EMPTY_MIN;
        r.depth = DEPTH_OUT_W'(level);
        r.empty = (level == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] exp_v,
                                   input logic [DATA_W-1:0] got_v);
        $display("%0t ns: mismatch on %s: expected %h, got %h", $time, field, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        stack_report_t e;
        if (rst_n)
        begin
            // Results retire before a transaction accepted at the same edge is queued.
            if (done)
            begin
                if (report_q.size() == 0)
                    report_mismatch("result with no transaction pending", '0, {31'b0, done});
                else
                begin
                    e = report_q.pop_front();
                    if (top_value !== e.top)
                        report_mismatch("top_value", e.top, top_value);
                    if (min_value !== e.minv)
                        report_mismatch("min_value", e.minv, min_value);
                    if (depth !== e.depth)
                        report_mismatch("depth", DATA_W'(e.depth), DATA_W'(depth));
                    if (empty_res !== e.empty)
                        report_mismatch("empty_res", DATA_W'(e.empty), DATA_W'(empty_res));
                    if (status !== e.st)
                        report_mismatch("status", DATA_W'(e.st), DATA_W'(status));
                end
            end
            if (start && !busy)
                report_q.push_back(apply_op(cmd, value));
        end
        outstanding <= report_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb
    import mts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int unsigned              ITEM_COUNT = 1300;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        cmd_r = OP_PUSH;
    logic signed [DATA_W-1:0]    value_r = '0;

    wire                         busy;
    wire                         done;
    wire signed [DATA_W-1:0]     top_value;
    wire signed [DATA_W-1:0]     min_value;
    wire [DEPTH_OUT_W-1:0]       depth;
    wire                         empty_res;
    wire [1:0]                   status;

    int                          fail_count;
    int                          outstanding;
    int                          level = 0;
    int                          sent = 0;
    bit                          idle_on = 1'b1;
    logic signed [DATA_W-1:0]    last_v = '0;

    min_tracking_stack_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd_r),
        .value     (value_r),
        .done      (done),
        .top_value (top_value),
        .min_value (min_value),
        .depth     (depth),
        .empty_res (empty_res),
        .status    (status)
    );

    min_tracking_stack_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd_r),
        .value       (value_r),
        .done        (done),
        .top_value   (top_value),
        .min_value   (min_value),
        .depth       (depth),
        .empty_res   (empty_res),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[min_tracking_stack_core] ERROR");
        $finish;
    end

    // Hold start until the block takes the transaction; idle beforehand at random.
    task automatic issue(input logic op, input logic signed [DATA_W-1:0] v);
        while (idle_on && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        cmd_r   <= op;
        value_r <= v;
        do
            @(posedge clk);
        while (busy);
        if (op == OP_PUSH && level < STACK_DEPTH_D)
            level++;
        else if (op == OP_POP && level > 0)
            level--;
        sent++;
        last_v = v;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input logic signed [DATA_W-1:0] prev);
        int k;
        k = $urandom_range(9);
        case (k)
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            5:       return $signed($urandom_range(16)) - 8;
            6:       return prev - $signed($urandom_range(1000));
            7:       return prev;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        int seg;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on empty, extremes, repeated minimum, drain past empty.
        issue(OP_POP, 32'sh1234_5678);
        issue(OP_PUSH, VAL_MAX);
        issue(OP_PUSH, VAL_MIN);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, VAL_MIN);
        issue(OP_PUSH, 32'sd5);
        repeat (6) issue(OP_POP, $urandom);
        issue(OP_POP, VAL_MIN);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PUSH, 32'shAAAA_AAAA);
        issue(OP_PUSH, -32'sd2);
        issue(OP_PUSH, VAL_MAX);
        repeat (4) issue(OP_POP, $urandom);
        wait_quiet();

        while (sent < ITEM_COUNT)
        begin
            // Drop idling for a long stretch in the middle.
            idle_on = !(sent >= 500 && sent < 800);
            seg = $urandom_range(9);
            if (seg < 2)
            begin
                while (level < STACK_DEPTH_D)
                    issue(OP_PUSH, pick_value(last_v));
                repeat ($urandom_range(3, 1)) issue(OP_PUSH, $urandom);
            end
            else if (seg < 4)
            begin
                while (level > 0)
                    issue(OP_POP, $urandom);
                repeat ($urandom_range(2, 1)) issue(OP_POP, $urandom);
            end
            else
            begin
                n = $urandom_range(40, 10);
                repeat (n)
                begin
                    if ($urandom_range(99) < 55)
                        issue(OP_PUSH, pick_value(last_v));
                    else
                        issue(OP_POP, $urandom);
                end
            end
            if ($urandom_range(7) == 0)
                wait_quiet();
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[min_tracking_stack_core] OK");
        else
            $display("[min_tracking_stack_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/mts_datapath.sv
rtl/mts_controller.sv
rtl/min_tracking_stack_core.sv
tb/sv/min_tracking_stack_checker.sv
tb/sv/tb.sv
